[design/ocp_pkg.sv]
// ----------------------------------------------------------------------------
// ocp_pkg
// Shared types and constants for the over-current trip/hold/blank block.
// ----------------------------------------------------------------------------
`default_nettype none

package ocp_pkg;

  // Configuration register file
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned TRIP_W    = 32;
  localparam int unsigned PHASE_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TRIP_RUN_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MS         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_MS        = 2'd2;

  localparam logic [CFG_W-1:0] RST_TRIP_RUN_LENGTH = 16'd8;
  localparam logic [CFG_W-1:0] RST_HOLD_MS         = 16'd200;
  localparam logic [CFG_W-1:0] RST_CYCLE_MS        = 16'd1000;

  // Item kinds carried in the mode field
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  // Configuration write as seen by the controller
  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
  } cfg_wr_t;

  // One item advancing through the controller
  typedef struct packed {
    logic valid;
    logic tick;
    logic pegged;
  } step_t;

  // Controller view after the item has been applied
  typedef struct packed {
    logic               hold;
    logic [PHASE_W-1:0] phase;
    logic [TRIP_W-1:0]  trips;
  } status_t;

endpackage

`default_nettype wire

[design/ocp_if.sv]
// ----------------------------------------------------------------------------
// ocp_if
// Valid/ready channels for sample/tick words in and drive words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ocp_in_if #(
  parameter int unsigned SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic                   mode;
  logic [SAMPLE_BITS-1:0] current_x;
  logic [SAMPLE_BITS-1:0] current_y;
  logic [SAMPLE_BITS-1:0] drive_x_cmd;
  logic [SAMPLE_BITS-1:0] drive_x_fb;
  logic [SAMPLE_BITS-1:0] drive_y_cmd;
  logic [SAMPLE_BITS-1:0] drive_y_fb;

  modport source (
    output valid, mode, current_x, current_y,
           drive_x_cmd, drive_x_fb, drive_y_cmd, drive_y_fb,
    input  ready
  );

  modport sink (
    input  valid, mode, current_x, current_y,
           drive_x_cmd, drive_x_fb, drive_y_cmd, drive_y_fb,
    output ready
  );
endinterface

interface ocp_out_if #(
  parameter int unsigned SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] out_x_cmd;
  logic [SAMPLE_BITS-1:0] out_x_fb;
  logic [SAMPLE_BITS-1:0] out_y_cmd;
  logic [SAMPLE_BITS-1:0] out_y_fb;
  logic [1:0]             protect_state;
  logic [31:0]            trip_total;

  modport source (
    output valid, out_x_cmd, out_x_fb, out_y_cmd, out_y_fb, protect_state, trip_total,
    input  ready
  );

  modport sink (
    input  valid, out_x_cmd, out_x_fb, out_y_cmd, out_y_fb, protect_state, trip_total,
    output ready
  );
endinterface

`default_nettype wire

[design/ocp_ctrl.sv]
// ----------------------------------------------------------------------------
// ocp_ctrl
// Protection sequencer: configuration registers, armed/hold/blank phase,
// pegged run count, elapsed milliseconds and trip counter.
// ----------------------------------------------------------------------------
`default_nettype none

module ocp_ctrl
  import ocp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire cfg_wr_t cfg,
  input  wire step_t   step,
  output status_t      status
);

  typedef enum logic [PHASE_W-1:0] {
    PH_ARMED = 2'd0,
    PH_HOLD  = 2'd1,
    PH_BLANK = 2'd2
  } phase_t;

  logic [CFG_W-1:0]  trip_run_length;
  logic [CFG_W-1:0]  hold_ms;
  logic [CFG_W-1:0]  cycle_ms;

  phase_t            phase;
  phase_t            phase_next;
  logic [CFG_W-1:0]  pegged_run;
  logic [CFG_W-1:0]  pegged_run_next;
  logic [CFG_W-1:0]  ms_since_trip;
  logic [CFG_W-1:0]  ms_since_trip_next;
  logic [TRIP_W-1:0] trip_counter;
  logic [TRIP_W-1:0] trip_counter_next;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      trip_run_length <= RST_TRIP_RUN_LENGTH;
      hold_ms         <= RST_HOLD_MS;
      cycle_ms        <= RST_CYCLE_MS;
    end else if (cfg.we) begin
      case (cfg.index)
        CFG_TRIP_RUN_LENGTH: trip_run_length <= cfg.data;
        CFG_HOLD_MS:         hold_ms         <= cfg.data;
        CFG_CYCLE_MS:        cycle_ms        <= cfg.data;
        default: ;
      endcase
    end
  end

  // Work out the state after one item
  always_comb begin
    logic [CFG_W-1:0] cap;
    logic [CFG_W-1:0] run_inc;
    phase_next         = phase;
    pegged_run_next    = pegged_run;
    ms_since_trip_next = ms_since_trip;
    trip_counter_next  = trip_counter;
    cap                = (cycle_ms > hold_ms) ? cycle_ms : hold_ms;
    run_inc            = '0;
    if (step.tick) begin
      // Advance elapsed time, saturating at the larger window
      ms_since_trip_next = (ms_since_trip < cap) ? ms_since_trip + 16'd1 : cap;
    end else begin
      // One phase step per sample
      case (phase)
        PH_ARMED: ;
        PH_HOLD: begin
          if (ms_since_trip >= hold_ms) begin
            phase_next      = PH_BLANK;
            pegged_run_next = '0;
          end
        end
        default: begin
          phase_next = (ms_since_trip >= cycle_ms) ? PH_ARMED : PH_BLANK;
        end
      endcase
      // Detect a run of pegged readings while armed
      if (phase_next == PH_ARMED) begin
        if (step.pegged) begin
          run_inc = (pegged_run_next == '1) ? pegged_run_next : pegged_run_next + 16'd1;
          if (run_inc > trip_run_length) begin
            phase_next         = PH_HOLD;
            ms_since_trip_next = '0;
            trip_counter_next  = trip_counter + 32'd1;
            pegged_run_next    = '0;
          end else begin
            pegged_run_next = run_inc;
          end
        end else begin
          pegged_run_next = '0;
        end
      end
    end
  end

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_ARMED;
      pegged_run    <= '0;
      ms_since_trip <= '0;
      trip_counter  <= '0;
    end else if (step.valid) begin
      phase         <= phase_next;
      pegged_run    <= pegged_run_next;
      ms_since_trip <= ms_since_trip_next;
      trip_counter  <= trip_counter_next;
    end
  end

  assign status.hold  = (phase_next == PH_HOLD);
  assign status.phase = phase_next;
  assign status.trips = trip_counter_next;

  // Entering hold always counts exactly one trip
  a_trip_count: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_HOLD) ##1 (phase == PH_HOLD) |-> trip_counter == $past(trip_counter) + 32'd1)
    else $error("hold entered without a single trip count");

  // A tick never moves the phase or the run
  a_tick_phase: assert property (@(posedge clk) disable iff (rst)
    step.valid && step.tick |=> $stable(phase) && $stable(pegged_run))
    else $error("tick changed phase or pegged run");

  // Hold only ever gives way to blank
  a_hold_exit: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HOLD) ##1 (phase != PH_HOLD) |-> phase == PH_BLANK)
    else $error("hold left to a phase other than blank");

  // The run is clear whenever detection is off
  a_run_clear: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_ARMED) |-> pegged_run == '0)
    else $error("pegged run nonzero outside armed");

endmodule

`default_nettype wire

[design/overcurrent_trip_hold_blank.sv]
// A sample word passes through the input register, then the result register;
// tick words produce no output.
// Throughput: one word per cycle unless a sample waits on a stalled output,
// set by the single-pass sequencer update between the two registers.
// Reset (rst, synchronous): pipeline empties, phase armed, counters cleared,
// registers back to trip run 8, hold 200 ms, cycle 1000 ms.
// ----------------------------------------------------------------------------
// overcurrent_trip_hold_blank
// Over-current trip with timed hold and blanking for two coil drive channels.
// ----------------------------------------------------------------------------
`default_nettype none

module overcurrent_trip_hold_blank
  import ocp_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  ocp_in_if.sink                    in_ch,
  ocp_out_if.source                 out_ch
);

  localparam logic [SAMPLE_BITS-1:0] MID_SCALE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Input register
  logic                   s1_valid;
  logic                   s1_mode;
  logic [SAMPLE_BITS-1:0] s1_current_x;
  logic [SAMPLE_BITS-1:0] s1_current_y;
  logic [SAMPLE_BITS-1:0] s1_x_cmd;
  logic [SAMPLE_BITS-1:0] s1_x_fb;
  logic [SAMPLE_BITS-1:0] s1_y_cmd;
  logic [SAMPLE_BITS-1:0] s1_y_fb;

  // Result register
  logic                   out_valid;
  logic [SAMPLE_BITS-1:0] out_x_cmd;
  logic [SAMPLE_BITS-1:0] out_x_fb;
  logic [SAMPLE_BITS-1:0] out_y_cmd;
  logic [SAMPLE_BITS-1:0] out_y_fb;
  logic [PHASE_W-1:0]     protect_state;
  logic [TRIP_W-1:0]      trip_total;

  logic    out_free;
  logic    s1_adv;
  logic    s1_tick;
  logic    in_ready;
  cfg_wr_t cfg;
  step_t   step;
  status_t status;

  // Handshake: ticks drain freely, samples need a free result slot
  assign s1_tick  = (s1_mode == MODE_TICK);
  assign out_free = !out_valid || out_ch.ready;
  assign s1_adv   = s1_valid && (s1_tick || out_free);
  assign in_ready = !s1_valid || s1_adv;

  // Capture accepted words
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_ch.valid;
    end
    if (in_ready && in_ch.valid) begin
      s1_mode      <= in_ch.mode;
      s1_current_x <= in_ch.current_x;
      s1_current_y <= in_ch.current_y;
      s1_x_cmd     <= in_ch.drive_x_cmd;
      s1_x_fb      <= in_ch.drive_x_fb;
      s1_y_cmd     <= in_ch.drive_y_cmd;
      s1_y_fb      <= in_ch.drive_y_fb;
    end
  end

  // Feed the sequencer
  assign cfg.we      = cfg_we;
  assign cfg.index   = cfg_index;
  assign cfg.data    = cfg_data;
  assign step.valid  = s1_adv;
  assign step.tick   = s1_tick;
  assign step.pegged = (s1_current_x == '0) || (s1_current_x == '1) ||
                       (s1_current_y == '0) || (s1_current_y == '1);

  ocp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .step   (step),
    .status (status)
  );

  // Load the result word, forcing safe levels while held
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_adv && !s1_tick;
    end
    if (out_free && s1_adv && !s1_tick) begin
      out_x_cmd     <= status.hold ? MID_SCALE : s1_x_cmd;
      out_x_fb      <= status.hold ? '0 : s1_x_fb;
      out_y_cmd     <= status.hold ? MID_SCALE : s1_y_cmd;
      out_y_fb      <= status.hold ? '0 : s1_y_fb;
      protect_state <= status.phase;
      trip_total    <= status.trips;
    end
  end

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid;
  assign out_ch.out_x_cmd     = out_x_cmd;
  assign out_ch.out_x_fb      = out_x_fb;
  assign out_ch.out_y_cmd     = out_y_cmd;
  assign out_ch.out_y_fb      = out_y_fb;
  assign out_ch.protect_state = protect_state;
  assign out_ch.trip_total    = trip_total;

endmodule

`default_nettype wire

[bench/ocp_checker.sv]
// ----------------------------------------------------------------------------
// ocp_checker
// Watches the sample/tick channel, the drive channel and the register port of
// the over-current guard, keeps its own copy of the trip, hold and blank
// sequence, and compares every drive word that leaves the block, field by
// field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module ocp_checker
  import ocp_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  ocp_in_if                    word_in,
  ocp_out_if                   word_out,
  output int                   mismatches,
  output int                   pending,
  output int                   results_checked,
  output logic [TRIP_W-1:0]    trips_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [SAMPLE_BITS-1:0] RAIL_HI  = {SAMPLE_BITS{1'b1}};
  localparam logic [SAMPLE_BITS-1:0] MID_WORD = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam int                     REPORT_MAX = 10;

  typedef enum logic [PHASE_W-1:0] {
    GUARD_ARMED = 2'd0,
    GUARD_HOLD  = 2'd1,
    GUARD_BLANK = 2'd2
  } guard_e;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] x_cmd;
    logic [SAMPLE_BITS-1:0] x_fb;
    logic [SAMPLE_BITS-1:0] y_cmd;
    logic [SAMPLE_BITS-1:0] y_fb;
    logic [PHASE_W-1:0]     state;
    logic [TRIP_W-1:0]      trips;
  } drive_word_t;

  // Register copies and sequencer state
  logic [CFG_W-1:0]  run_limit;
  logic [CFG_W-1:0]  hold_limit;
  logic [CFG_W-1:0]  cycle_limit;
  guard_e            guard;
  logic [15:0]       peg_run;
  logic [15:0]       ms_elapsed;
  logic [TRIP_W-1:0] trip_count;

  drive_word_t drive_q[$];
  int          bad_words = 0;
  int          checked   = 0;

  function automatic logic at_rail(input logic [SAMPLE_BITS-1:0] level);
    return (level == '0) || (level == RAIL_HI);
  endfunction

  // Apply one accepted word to the sequencer; queue the drive word of a sample
  task automatic advance_guard(input logic mode,
                               input logic [SAMPLE_BITS-1:0] cx, cy,
                               input logic [SAMPLE_BITS-1:0] xc, xf, yc, yf);
    logic [CFG_W-1:0] ms_cap;
    drive_word_t      w;
    if (mode == MODE_TICK) begin
      // elapsed time saturates at the larger of the two windows
      ms_cap = (cycle_limit > hold_limit) ? cycle_limit : hold_limit;
      if (ms_elapsed < ms_cap) begin
        ms_elapsed = ms_elapsed + 16'd1;
      end else begin
        ms_elapsed = ms_cap;
      end
    end else begin
      // one phase step per sample, timed from the trip
      case (guard)
        GUARD_ARMED: ;
        GUARD_HOLD: begin
          if (ms_elapsed >= hold_limit) begin
            guard   = GUARD_BLANK;
            peg_run = '0;
          end
        end
        default: begin
          if (ms_elapsed >= cycle_limit) begin
            guard = GUARD_ARMED;
          end else begin
            guard = GUARD_BLANK;
          end
        end
      endcase

      // detection only while armed
      if (guard == GUARD_ARMED) begin
        if (at_rail(cx) || at_rail(cy)) begin
          if (peg_run != 16'hFFFF) begin
            peg_run = peg_run + 16'd1;
          end
          if (peg_run > run_limit) begin
            guard      = GUARD_HOLD;
            ms_elapsed = '0;
            trip_count = trip_count + 1'b1;
            peg_run    = '0;
          end
        end else begin
          peg_run = '0;
        end
      end

      // force safe words in hold, pass through otherwise
      if (guard == GUARD_HOLD) begin
        w.x_cmd = MID_WORD;
        w.x_fb  = '0;
        w.y_cmd = MID_WORD;
        w.y_fb  = '0;
      end else begin
        w.x_cmd = xc;
        w.x_fb  = xf;
        w.y_cmd = yc;
        w.y_fb  = yf;
      end
      w.state = guard;
      w.trips = trip_count;
      drive_q.push_back(w);
    end
  endtask

  // Compare one drive word from the block with the oldest prediction
  task automatic check_drive_word();
    drive_word_t want;
    if (drive_q.size() == 0) begin
      bad_words++;
      if (bad_words <= REPORT_MAX) begin
        $display("drive word with nothing predicted: %h %h %h %h st%0d tr%0d",
                 word_out.out_x_cmd, word_out.out_x_fb, word_out.out_y_cmd,
                 word_out.out_y_fb, word_out.protect_state, word_out.trip_total);
      end
    end else begin
      want = drive_q.pop_front();
      checked++;
      if (word_out.out_x_cmd !== want.x_cmd || word_out.out_x_fb !== want.x_fb ||
          word_out.out_y_cmd !== want.y_cmd || word_out.out_y_fb !== want.y_fb ||
          word_out.protect_state !== want.state || word_out.trip_total !== want.trips) begin
        bad_words++;
        if (bad_words <= REPORT_MAX) begin
          $display("mismatch %0d exp %h %h %h %h st%0d tr%0d got %h %h %h %h st%0d tr%0d",
                   bad_words, want.x_cmd, want.x_fb, want.y_cmd, want.y_fb,
                   want.state, want.trips,
                   word_out.out_x_cmd, word_out.out_x_fb, word_out.out_y_cmd,
                   word_out.out_y_fb, word_out.protect_state, word_out.trip_total);
        end
      end
    end
  endtask

  // Registers first, then the drive word leaving, then the word arriving
  always @(posedge clk) begin
    if (rst) begin
      run_limit   = RST_TRIP_RUN_LENGTH;
      hold_limit  = RST_HOLD_MS;
      cycle_limit = RST_CYCLE_MS;
      guard       = GUARD_ARMED;
      peg_run     = '0;
      ms_elapsed  = '0;
      trip_count  = '0;
      drive_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TRIP_RUN_LENGTH: run_limit   = cfg_data;
          CFG_HOLD_MS:         hold_limit  = cfg_data;
          CFG_CYCLE_MS:        cycle_limit = cfg_data;
          default: ;
        endcase
      end
      if (word_out.valid && word_out.ready) begin
        check_drive_word();
      end
      if (word_in.valid && word_in.ready) begin
        advance_guard(word_in.mode, word_in.current_x, word_in.current_y,
                      word_in.drive_x_cmd, word_in.drive_x_fb,
                      word_in.drive_y_cmd, word_in.drive_y_fb);
      end
    end
    mismatches      <= bad_words;
    pending         <= drive_q.size();
    results_checked <= checked;
    trips_seen      <= trip_count;
  end

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Drives sample and tick words into the over-current guard under a range of
// trip, hold and blank settings, with random gaps on the input, random and
// long stalls on the output, and pauses for the pipeline to empty; the
// checker beside the block predicts and compares every drive word.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ocp_pkg::*;

  localparam int unsigned          SB             = 12;
  localparam logic [SB-1:0]        RAIL_HI        = {SB{1'b1}};
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE      = 2'd3;
  localparam int                   PHASES         = 10;
  localparam int                   PHASE_WORDS    = 110;
  localparam int                   LONG_STALL     = 150;
  localparam int                   WATCHDOG_LIMIT = 2000;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int                mismatches;
  int                pending;
  int                results_checked;
  logic [TRIP_W-1:0] trips_seen;

  int samples_sent    = 0;
  int ticks_sent      = 0;
  int settings_loaded = 0;
  int idle_cycles     = 0;
  bit gaps_on         = 1'b0;
  bit stalls_on       = 1'b0;
  bit long_stall_req  = 1'b0;
  bit long_stall_done = 1'b0;

  ocp_in_if  #(.SAMPLE_BITS(SB)) in_ch ();
  ocp_out_if #(.SAMPLE_BITS(SB)) out_ch ();

  overcurrent_trip_hold_blank #(.SAMPLE_BITS(SB)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  ocp_checker #(.SAMPLE_BITS(SB)) u_check (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .word_in         (in_ch),
    .word_out        (out_ch),
    .mismatches      (mismatches),
    .pending         (pending),
    .results_checked (results_checked),
    .trips_seen      (trips_seen)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic [SB-1:0] any_level();
    return SB'($urandom_range(0, RAIL_HI));
  endfunction

  // Offer one word, after an optional gap, and hold it until taken
  task automatic send_word(input logic mode, input logic [SB-1:0] cx, cy,
                           input logic [SB-1:0] xc, xf, yc, yf);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= mode;
    in_ch.current_x   <= cx;
    in_ch.current_y   <= cy;
    in_ch.drive_x_cmd <= xc;
    in_ch.drive_x_fb  <= xf;
    in_ch.drive_y_cmd <= yc;
    in_ch.drive_y_fb  <= yf;
    do @(posedge clk); while (!in_ch.ready);
    if (mode == MODE_TICK) begin
      ticks_sent++;
    end else begin
      samples_sent++;
    end
  endtask

  // Stop offering, wait for every drive word, then let a trailing tick settle
  task automatic drain(input int settle);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (settle) @(posedge clk);
  endtask

  // Write all three limits, plus the unused index, on the idle block
  task automatic load_limits(input logic [CFG_W-1:0] run_len, hold, cycle);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SPARE;
    cfg_data  <= CFG_W'($urandom);
    @(posedge clk);
    cfg_index <= CFG_TRIP_RUN_LENGTH;
    cfg_data  <= run_len;
    @(posedge clk);
    cfg_index <= CFG_HOLD_MS;
    cfg_data  <= hold;
    @(posedge clk);
    cfg_index <= CFG_CYCLE_MS;
    cfg_data  <= cycle;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  // Output side: random stall bursts, one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_stall_req && !long_stall_done) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        long_stall_done = 1'b1;
        out_ch.ready <= 1'b1;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if no word moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d drive words outstanding",
               idle_cycles, pending);
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    logic [CFG_W-1:0] run_len;
    logic [CFG_W-1:0] hold;
    logic [CFG_W-1:0] cycle;
    logic [SB-1:0]    peg;
    logic [SB-1:0]    cx;
    logic [SB-1:0]    cy;
    int               sel;
    int               burst;
    int               start;

    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_TRIP_RUN_LENGTH;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.mode        <= MODE_SAMPLE;
    in_ch.current_x   <= '0;
    in_ch.current_y   <= '0;
    in_ch.drive_x_cmd <= '0;
    in_ch.drive_x_fb  <= '0;
    in_ch.drive_y_cmd <= '0;
    in_ch.drive_y_fb  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset limits: near-rail passes, a broken run, then a full run
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    send_word(MODE_SAMPLE, 12'd1, SB'(RAIL_HI - 1), '0, RAIL_HI, '0, RAIL_HI);
    send_word(MODE_SAMPLE, 12'd2048, 12'd2048, RAIL_HI, '0, RAIL_HI, '0);
    send_word(MODE_SAMPLE, 12'd100, '0, any_level(), any_level(), any_level(), any_level());
    send_word(MODE_SAMPLE, RAIL_HI, 12'd100, any_level(), any_level(), any_level(),
              any_level());
    send_word(MODE_SAMPLE, 12'd300, 12'd400, any_level(), any_level(), any_level(),
              any_level());
    for (int i = 0; i < 9; i++) begin
      cx = (i % 2 == 1) ? RAIL_HI : '0;
      cy = (i % 3 == 0) ? RAIL_HI : SB'(5 + i);
      send_word(MODE_SAMPLE, cx, cy, any_level(), any_level(), any_level(), any_level());
    end
    // held: words forced, rail readings ignored
    send_word(MODE_SAMPLE, 12'd50, 12'd60, RAIL_HI, RAIL_HI, RAIL_HI, RAIL_HI);
    send_word(MODE_TICK, any_level(), any_level(), any_level(), any_level(), any_level(),
              any_level());
    send_word(MODE_SAMPLE, '0, RAIL_HI, RAIL_HI, RAIL_HI, RAIL_HI, RAIL_HI);
    drain(4);

    // Directed, zero limits: leave hold, re-arm, trip on the first rail sample
    load_limits('0, '0, '0);
    send_word(MODE_SAMPLE, 12'd700, 12'd800, any_level(), any_level(), any_level(),
              any_level());
    send_word(MODE_SAMPLE, 12'd700, 12'd800, any_level(), any_level(), any_level(),
              any_level());
    send_word(MODE_SAMPLE, 12'd10, RAIL_HI, any_level(), any_level(), any_level(),
              any_level());
    send_word(MODE_SAMPLE, '0, '0, any_level(), any_level(), any_level(), any_level());
    send_word(MODE_SAMPLE, RAIL_HI, 12'd9, any_level(), any_level(), any_level(),
              any_level());
    send_word(MODE_TICK, any_level(), any_level(), any_level(), any_level(), any_level(),
              any_level());
    send_word(MODE_SAMPLE, 12'd20, '0, any_level(), any_level(), any_level(), any_level());
    drain(4);

    // Random phases, each under its own limits
    for (int p = 0; p < PHASES; p++) begin
      run_len = CFG_W'($urandom_range(0, 5));
      hold    = CFG_W'($urandom_range(0, 8));
      cycle   = CFG_W'($urandom_range(0, 16));
      case (p)
        2: run_len = 16'hFFFF;
        4: begin
          run_len = '0;
          hold    = 16'hFFFF;
          cycle   = 16'hFFFF;
        end
        5: begin
          hold  = 16'd7;
          cycle = 16'd2;
        end
        6: begin
          run_len = 16'd1;
          hold    = 16'd1;
          cycle   = 16'hFFFF;
        end
        default: ;
      endcase
      gaps_on   = (p % 3 != 1) && (p < PHASES - 2);
      stalls_on = gaps_on;
      load_limits(run_len, hold, cycle);
      if (p == 3) begin
        long_stall_req = 1'b1;
      end
      start = samples_sent + ticks_sent;
      while (samples_sent + ticks_sent - start < PHASE_WORDS) begin
        // a run of rail samples around the trip length
        burst = $urandom_range(0, (run_len > 8) ? 10 : run_len + 2);
        repeat (burst) begin
          peg = $urandom_range(0, 1) ? RAIL_HI : '0;
          sel = $urandom_range(0, 2);
          cx  = (sel != 1) ? peg : any_level();
          cy  = (sel != 0) ? ($urandom_range(0, 1) ? RAIL_HI : '0) : any_level();
          send_word(MODE_SAMPLE, cx, cy, any_level(), any_level(), any_level(),
                    any_level());
        end
        // then time passing, with quiet and arbitrary samples
        repeat ($urandom_range(1, 16)) begin
          sel = $urandom_range(0, 9);
          if (sel < 5) begin
            send_word(MODE_TICK, any_level(), any_level(), any_level(), any_level(),
                      any_level(), any_level());
          end else if (sel < 9) begin
            send_word(MODE_SAMPLE, SB'($urandom_range(1, RAIL_HI - 1)),
                      SB'($urandom_range(1, RAIL_HI - 1)), any_level(), any_level(),
                      any_level(), any_level());
          end else begin
            send_word(MODE_SAMPLE, any_level(), any_level(), any_level(), any_level(),
                      any_level(), any_level());
          end
        end
      end
      drain(4);
    end

    drain(12);
    $display("Run covered %0d samples and %0d ticks under %0d limit settings.",
             samples_sent, ticks_sent, settings_loaded);
    $display("%0d drive words checked, trip count reached %0d.", results_checked, trips_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

[filelist.f]
design/ocp_pkg.sv
design/ocp_if.sv
design/ocp_ctrl.sv
design/overcurrent_trip_hold_blank.sv
bench/ocp_checker.sv
bench/tb.sv
